FILE: rtl/ikn_pkg.sv
// ----------------------------------------------------------------------------
// ikn_pkg: shared types and constants of the two-link inverse kinematics unit
// Field widths, internal datapath widths, register codes and the CORDIC
// arctangent table in Q30.
// ----------------------------------------------------------------------------
package ikn_pkg;

    localparam int COORD_W   = 20;
    localparam int LEN_W     = 19;
    localparam int ANG_W     = 18;
    localparam int WORK_FRAC = 30;

    // Squares and the c2 numerator.
    localparam int SQ_W  = 39;
    localparam int LSQ_W = 2 * LEN_W;
    localparam int NUM_W = 41;
    localparam int MAG_W = 40;
    localparam int DEN_W = 39;

    // Quotient, square root and CORDIC vectors.
    localparam int QW    = WORK_FRAC + 1;
    localparam int C2_W  = WORK_FRAC + 2;
    localparam int S2_W  = WORK_FRAC + 1;
    localparam int VW    = 62;
    localparam int CW    = 56;
    localparam int ZW    = 34;

    localparam int DEF_ANGLE_FRAC_BITS = 14;
    localparam int DEF_CORDIC_STAGES   = 16;

    localparam logic [LEN_W-1:0] L1_RESET = 19'd40960;
    localparam logic [LEN_W-1:0] L2_RESET = 19'd28672;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Register index codes (paddr bit 2).
    localparam logic REG_FIRST_ARM  = 1'b0;
    localparam logic REG_SECOND_ARM = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [LEN_W-1:0]          l1;
        logic [LEN_W-1:0]          l2;
        logic                      flag;
    } t_geo;

    typedef struct packed {
        t_geo             geo;
        logic             neg;
        logic [DEN_W-1:0] den;
    } t_div_side;

    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        case (idx)
            0:  atan_entry = 34'sd843314857;
            1:  atan_entry = 34'sd497837829;
            2:  atan_entry = 34'sd263043837;
            3:  atan_entry = 34'sd133525159;
            4:  atan_entry = 34'sd67021687;
            5:  atan_entry = 34'sd33543516;
            6:  atan_entry = 34'sd16775851;
            7:  atan_entry = 34'sd8388437;
            8:  atan_entry = 34'sd4194283;
            9:  atan_entry = 34'sd2097149;
            10: atan_entry = 34'sd1048576;
            11: atan_entry = 34'sd524288;
            12: atan_entry = 34'sd262144;
            13: atan_entry = 34'sd131072;
            14: atan_entry = 34'sd65536;
            15: atan_entry = 34'sd32768;
            16: atan_entry = 34'sd16384;
            17: atan_entry = 34'sd8192;
            18: atan_entry = 34'sd4096;
            19: atan_entry = 34'sd2048;
            20: atan_entry = 34'sd1024;
            21: atan_entry = 34'sd512;
            22: atan_entry = 34'sd256;
            23: atan_entry = 34'sd128;
            24: atan_entry = 34'sd64;
            25: atan_entry = 34'sd32;
            26: atan_entry = 34'sd16;
            27: atan_entry = 34'sd8;
            28: atan_entry = 34'sd4;
            29: atan_entry = 34'sd2;
            30: atan_entry = 34'sd1;
            default: atan_entry = '0;
        endcase
    endfunction

endpackage

FILE: rtl/ikn_front.sv
// ----------------------------------------------------------------------------
// ikn_front: input capture, squares and c2 numerator
// Three stages: capture, five products, numerator magnitude and reach check.
// ----------------------------------------------------------------------------
module ikn_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [ikn_pkg::COORD_W-1:0]   i_x,
    input  logic signed [ikn_pkg::COORD_W-1:0]   i_y,
    input  logic [ikn_pkg::LEN_W-1:0]            i_l1,
    input  logic [ikn_pkg::LEN_W-1:0]            i_l2,
    output logic                                 o_valid,
    output logic [ikn_pkg::MAG_W-1:0]            o_mag,
    output ikn_pkg::t_div_side                   o_side
);

    logic                                r_v1, r_v2, r_v3;
    logic signed [ikn_pkg::COORD_W-1:0]  r_x1, r_y1, r_x2, r_y2;
    logic [ikn_pkg::LEN_W-1:0]           r_l1_1, r_l2_1, r_l1_2, r_l2_2;
    logic [ikn_pkg::SQ_W-1:0]            r_xx, r_yy;
    logic [ikn_pkg::LSQ_W-1:0]           r_l11, r_l22, r_l12;
    logic [ikn_pkg::MAG_W-1:0]           r_mag;
    ikn_pkg::t_div_side                  r_side;

    logic signed [2*ikn_pkg::COORD_W-1:0] n_xx_full, n_yy_full;
    logic [ikn_pkg::LSQ_W-1:0]            n_l11, n_l22, n_l12;
    logic signed [ikn_pkg::NUM_W-1:0]     n_num, n_abs;
    logic [ikn_pkg::DEN_W-1:0]            n_den;
    logic [ikn_pkg::MAG_W-1:0]            n_mag;
    logic                                 n_flag;

    always_comb begin
        n_xx_full = r_x1 * r_x1;
        n_yy_full = r_y1 * r_y1;
        n_l11     = r_l1_1 * r_l1_1;
        n_l22     = r_l2_1 * r_l2_1;
        n_l12     = r_l1_1 * r_l2_1;
        n_num = $signed({2'b00, r_xx}) + $signed({2'b00, r_yy})
              - $signed({3'b000, r_l11}) - $signed({3'b000, r_l22});
        n_abs  = n_num[ikn_pkg::NUM_W-1] ? -n_num : n_num;
        n_mag  = n_abs[ikn_pkg::MAG_W-1:0];
        n_den  = {r_l12, 1'b0};
        // A zero arm length leaves no usable denominator; it is flagged too.
        n_flag = (n_den == '0) || (n_mag > {1'b0, n_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1   <= i_x;
            r_y1   <= i_y;
            r_l1_1 <= i_l1;
            r_l2_1 <= i_l2;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_l1_2 <= r_l1_1;
            r_l2_2 <= r_l2_1;
            r_xx   <= n_xx_full[ikn_pkg::SQ_W-1:0];
            r_yy   <= n_yy_full[ikn_pkg::SQ_W-1:0];
            r_l11  <= n_l11;
            r_l22  <= n_l22;
            r_l12  <= n_l12;
            r_mag  <= n_mag;
            r_side.geo.x    <= r_x2;
            r_side.geo.y    <= r_y2;
            r_side.geo.l1   <= r_l1_2;
            r_side.geo.l2   <= r_l2_2;
            r_side.geo.flag <= n_flag;
            r_side.neg      <= n_num[ikn_pkg::NUM_W-1];
            r_side.den      <= n_den;
        end
    end

    assign o_valid = r_v3;
    assign o_mag   = r_mag;
    assign o_side  = r_side;

endmodule

FILE: rtl/ikn_div.sv
// ----------------------------------------------------------------------------
// ikn_div: pipelined restoring divider for |c2|
// One quotient bit per stage, integer bit first, then the 30 fraction bits.
// ----------------------------------------------------------------------------
module ikn_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [ikn_pkg::MAG_W-1:0]    i_mag,
    input  ikn_pkg::t_div_side           i_side,
    output logic                         o_valid,
    output logic [ikn_pkg::QW-1:0]       o_q,
    output ikn_pkg::t_div_side           o_side
);

    localparam int N = ikn_pkg::QW;

    logic                        r_v [0:N-1];
    logic [ikn_pkg::MAG_W-1:0]   r_r [0:N-1];
    logic [ikn_pkg::QW-1:0]      r_q [0:N-1];
    ikn_pkg::t_div_side          r_s [0:N-1];

    logic [ikn_pkg::MAG_W-1:0]   n_d0;
    logic                        n_ge0;

    always_comb begin
        n_d0  = {1'b0, i_side.den};
        n_ge0 = i_mag >= n_d0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0] <= n_ge0 ? i_mag - n_d0 : i_mag;
            r_q[0] <= {{(N-1){1'b0}}, n_ge0};
            r_s[0] <= i_side;
        end
    end

    for (genvar k = 1; k < N; k++) begin : g_bit
        logic [ikn_pkg::MAG_W-1:0] n_sh, n_d;
        logic                      n_ge;

        always_comb begin
            n_sh = {r_r[k-1][ikn_pkg::MAG_W-2:0], 1'b0};
            n_d  = {1'b0, r_s[k-1].den};
            n_ge = n_sh >= n_d;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k] <= n_ge ? n_sh - n_d : n_sh;
                r_q[k] <= {r_q[k-1][N-2:0], n_ge};
                r_s[k] <= r_s[k-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_q     = r_q[N-1];
    assign o_side  = r_s[N-1];

endmodule

FILE: rtl/ikn_sqrt.sv
// ----------------------------------------------------------------------------
// ikn_sqrt: signed c2, pipelined integer square root for s2, CORDIC operands
// Clamp and sign, square, 2^60 - c2^2, 31 root stages, then k1 and k2.
// ----------------------------------------------------------------------------
module ikn_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [ikn_pkg::QW-1:0]            i_q,
    input  ikn_pkg::t_div_side                i_side,
    output logic                              o_valid,
    output logic signed [ikn_pkg::CW-1:0]     o_k1,
    output logic signed [ikn_pkg::CW-1:0]     o_k2,
    output logic signed [ikn_pkg::C2_W-1:0]   o_c2,
    output logic [ikn_pkg::S2_W-1:0]          o_s2,
    output ikn_pkg::t_geo                     o_geo
);

    localparam int N     = ikn_pkg::QW;
    localparam int P_W   = ikn_pkg::LEN_W + 1 + ikn_pkg::C2_W;
    localparam int K2P_W = ikn_pkg::LEN_W + ikn_pkg::S2_W;
    localparam logic [ikn_pkg::QW-1:0] ONE_Q = ikn_pkg::QW'(1) << ikn_pkg::WORK_FRAC;

    // Clamp, sign and square.
    logic                              r_va;
    logic signed [ikn_pkg::C2_W-1:0]   r_c2a;
    logic [2*ikn_pkg::QW-1:0]          r_sq;
    ikn_pkg::t_geo                     r_geoa;
    logic [ikn_pkg::QW-1:0]            n_qe;

    always_comb begin
        n_qe = i_side.geo.flag ? ONE_Q : i_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c2a  <= i_side.neg ? -$signed({1'b0, n_qe}) : $signed({1'b0, n_qe});
            r_sq   <= n_qe * n_qe;
            r_geoa <= i_side.geo;
        end
    end

    // Root pipeline: index 0 holds the radicand, index k+1 the result of step k.
    logic                              r_vs   [0:N];
    logic [ikn_pkg::VW-1:0]            r_rad  [0:N];
    logic [ikn_pkg::VW-1:0]            r_root [0:N];
    logic signed [ikn_pkg::C2_W-1:0]   r_c2s  [0:N];
    ikn_pkg::t_geo                     r_geos [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs[0] <= 1'b0;
        end else if (i_en) begin
            r_vs[0] <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= (ikn_pkg::VW'(1) << (2 * ikn_pkg::WORK_FRAC)) - r_sq;
            r_root[0] <= '0;
            r_c2s[0]  <= r_c2a;
            r_geos[0] <= r_geoa;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_root
        localparam logic [ikn_pkg::VW-1:0] BIT = ikn_pkg::VW'(1) << (2 * (N - 1 - k));
        logic [ikn_pkg::VW-1:0] n_t;
        logic                   n_ge;

        always_comb begin
            n_t  = r_root[k] + BIT;
            n_ge = r_rad[k] >= n_t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vs[k+1] <= r_vs[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= n_ge ? r_rad[k] - n_t : r_rad[k];
                r_root[k+1] <= n_ge ? (r_root[k] >> 1) + BIT : (r_root[k] >> 1);
                r_c2s[k+1]  <= r_c2s[k];
                r_geos[k+1] <= r_geos[k];
            end
        end
    end

    // Products l2*c2 and l2*s2, then k1 = l1*2^30 + l2*c2.
    logic                              r_vp, r_vk;
    logic signed [P_W-1:0]             r_p;
    logic [K2P_W-1:0]                  r_k2p;
    logic signed [ikn_pkg::C2_W-1:0]   r_c2p, r_c2k;
    logic [ikn_pkg::S2_W-1:0]          r_s2p, r_s2k;
    ikn_pkg::t_geo                     r_geop, r_geok;
    logic signed [ikn_pkg::CW-1:0]     r_k1, r_k2;
    logic [ikn_pkg::S2_W-1:0]          n_s2;

    always_comb begin
        n_s2 = r_root[N][ikn_pkg::S2_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vk <= 1'b0;
        end else if (i_en) begin
            r_vp <= r_vs[N];
            r_vk <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= $signed({1'b0, r_geos[N].l2}) * r_c2s[N];
            r_k2p  <= r_geos[N].l2 * n_s2;
            r_c2p  <= r_c2s[N];
            r_s2p  <= n_s2;
            r_geop <= r_geos[N];
            r_k1   <= $signed({{(ikn_pkg::CW-ikn_pkg::LEN_W-ikn_pkg::WORK_FRAC){1'b0}},
                               r_geop.l1, {ikn_pkg::WORK_FRAC{1'b0}}})
                    + $signed({{(ikn_pkg::CW-P_W){r_p[P_W-1]}}, r_p});
            r_k2   <= $signed({{(ikn_pkg::CW-K2P_W){1'b0}}, r_k2p});
            r_c2k  <= r_c2p;
            r_s2k  <= r_s2p;
            r_geok <= r_geop;
        end
    end

    assign o_valid = r_vk;
    assign o_k1    = r_k1;
    assign o_k2    = r_k2;
    assign o_c2    = r_c2k;
    assign o_s2    = r_s2k;
    assign o_geo   = r_geok;

endmodule

FILE: rtl/ikn_cordic.sv
// ----------------------------------------------------------------------------
// ikn_cordic: pipelined vectoring CORDIC giving atan2(y, x) in Q30
// A pre-rotation stage for negative x, then one micro-rotation per stage.
// ----------------------------------------------------------------------------
module ikn_cordic #(
    parameter int STAGES = ikn_pkg::DEF_CORDIC_STAGES
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [ikn_pkg::CW-1:0]    i_x,
    input  logic signed [ikn_pkg::CW-1:0]    i_y,
    output logic signed [ikn_pkg::ZW-1:0]    o_z
);

    logic signed [ikn_pkg::CW-1:0] r_x    [0:STAGES];
    logic signed [ikn_pkg::CW-1:0] r_y    [0:STAGES];
    logic signed [ikn_pkg::ZW-1:0] r_z    [0:STAGES];
    logic                          r_zero [0:STAGES];

    logic signed [ikn_pkg::CW-1:0] n_x, n_y;
    logic signed [ikn_pkg::ZW-1:0] n_z;

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = '0;
        if (i_x[ikn_pkg::CW-1]) begin
            if (!i_y[ikn_pkg::CW-1]) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = ikn_pkg::HALF_PI_Q30;
            end else begin
                n_x = -i_y;
                n_y = i_x;
                n_z = -ikn_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_z[0]    <= n_z;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ikn_pkg::ZW-1:0] ATAN = ikn_pkg::atan_entry(i);
        logic signed [ikn_pkg::CW-1:0] n_sx, n_sy;
        logic signed [ikn_pkg::ZW-1:0] n_sz;

        always_comb begin
            if (!r_y[i][ikn_pkg::CW-1]) begin
                n_sx = r_x[i] + (r_y[i] >>> i);
                n_sy = r_y[i] - (r_x[i] >>> i);
                n_sz = r_z[i] + ATAN;
            end else begin
                n_sx = r_x[i] - (r_y[i] >>> i);
                n_sy = r_y[i] + (r_x[i] >>> i);
                n_sz = r_z[i] - ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_sx;
                r_y[i+1]    <= n_sy;
                r_z[i+1]    <= n_sz;
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign o_z = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

FILE: rtl/two_link_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// two_link_inverse_kinematics_unit: elbow-up inverse kinematics, two-link arm
// Target point in, shoulder and elbow angles plus an out-of-reach flag out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries a target (x, y); output channel
//   o_valid/i_ready carries the two joint angles and the reach flag. Arm
//   lengths are written over the APB port (first arm at 0x0, second at 0x4);
//   the user must write them only while no transfer is in flight, as the
//   block itself does not enforce this. Reads return the stored lengths.
//   The datapath is one pipeline: three stages of squares, 31 divider
//   stages, 35 stages of square root and operand forming, CORDIC_STAGES + 1
//   stages for the three parallel CORDICs, one rounding stage and the
//   output register. One transfer is taken each cycle while o_ready is high.
//   When the receiver stalls, one more result drops into a skid register,
//   then the whole pipeline holds with o_ready low; nothing is lost.
//   Reset clears all valid bits and restores the arm lengths to 10.0 and 7.0.
// ----------------------------------------------------------------------------
module two_link_inverse_kinematics_unit #(
    parameter int ANGLE_FRAC_BITS = ikn_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = ikn_pkg::DEF_CORDIC_STAGES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [ikn_pkg::COORD_W-1:0] i_target_x,
    input  logic signed [ikn_pkg::COORD_W-1:0] i_target_y,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [ikn_pkg::ANG_W-1:0]   o_shoulder_angle,
    output logic signed [ikn_pkg::ANG_W-1:0]   o_elbow_angle,
    output logic                               o_out_of_reach
);

    localparam int SH = ikn_pkg::WORK_FRAC - ANGLE_FRAC_BITS;
    localparam int AW = ikn_pkg::ZW + 2;
    localparam logic signed [AW-1:0] ANG_HI = AW'((2 ** (ikn_pkg::ANG_W - 1)) - 1);
    localparam logic signed [AW-1:0] ANG_LO = -ANG_HI - AW'(1);
    localparam logic signed [AW-1:0] HALF   = AW'(1) << (SH - 1);

    // Configuration registers.
    logic [ikn_pkg::LEN_W-1:0] r_l1, r_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= ikn_pkg::L1_RESET;
            r_l2 <= ikn_pkg::L2_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                ikn_pkg::REG_FIRST_ARM:  r_l1 <= pwdata[ikn_pkg::LEN_W-1:0];
                ikn_pkg::REG_SECOND_ARM: r_l2 <= pwdata[ikn_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ikn_pkg::REG_SECOND_ARM)
                  ? {{(32-ikn_pkg::LEN_W){1'b0}}, r_l2}
                  : {{(32-ikn_pkg::LEN_W){1'b0}}, r_l1};

    // The pipeline advances whenever the skid register is free.
    logic r_ov, r_sv;
    logic en;

    assign en      = !r_sv;
    assign o_ready = en;

    logic                          f_valid;
    logic [ikn_pkg::MAG_W-1:0]     f_mag;
    ikn_pkg::t_div_side            f_side;
    logic                          d_valid;
    logic [ikn_pkg::QW-1:0]        d_q;
    ikn_pkg::t_div_side            d_side;
    logic                          s_valid;
    logic signed [ikn_pkg::CW-1:0] s_k1, s_k2;
    logic signed [ikn_pkg::C2_W-1:0] s_c2;
    logic [ikn_pkg::S2_W-1:0]      s_s2;
    ikn_pkg::t_geo                 s_geo;

    ikn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_x     (i_target_x),
        .i_y     (i_target_y),
        .i_l1    (r_l1),
        .i_l2    (r_l2),
        .o_valid (f_valid),
        .o_mag   (f_mag),
        .o_side  (f_side)
    );

    ikn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_mag   (f_mag),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_side  (d_side)
    );

    ikn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (d_valid),
        .i_q     (d_q),
        .i_side  (d_side),
        .o_valid (s_valid),
        .o_k1    (s_k1),
        .o_k2    (s_k2),
        .o_c2    (s_c2),
        .o_s2    (s_s2),
        .o_geo   (s_geo)
    );

    // Three angles in parallel: atan2(y, x), atan2(k2, k1), atan2(s2, c2).
    logic signed [ikn_pkg::CW-1:0] xy_x, xy_y, el_x, el_y;
    logic signed [ikn_pkg::ZW-1:0] z_xy, z_k, z_el;

    localparam int XPAD = ikn_pkg::CW - ikn_pkg::COORD_W - ikn_pkg::WORK_FRAC;

    assign xy_x = {{XPAD{s_geo.x[ikn_pkg::COORD_W-1]}}, s_geo.x, {ikn_pkg::WORK_FRAC{1'b0}}};
    assign xy_y = {{XPAD{s_geo.y[ikn_pkg::COORD_W-1]}}, s_geo.y, {ikn_pkg::WORK_FRAC{1'b0}}};
    assign el_x = {{(ikn_pkg::CW-ikn_pkg::C2_W){s_c2[ikn_pkg::C2_W-1]}}, s_c2};
    assign el_y = {{(ikn_pkg::CW-ikn_pkg::S2_W){1'b0}}, s_s2};

    ikn_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_xy (
        .i_clk (i_clk), .i_en (en), .i_x (xy_x), .i_y (xy_y), .o_z (z_xy)
    );

    ikn_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_k (
        .i_clk (i_clk), .i_en (en), .i_x (s_k1), .i_y (s_k2), .o_z (z_k)
    );

    ikn_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_el (
        .i_clk (i_clk), .i_en (en), .i_x (el_x), .i_y (el_y), .o_z (z_el)
    );

    // Valid and reach flag ride alongside the CORDIC stages.
    logic r_cv [0:CORDIC_STAGES];
    logic r_cf [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CORDIC_STAGES; i++) begin
                r_cv[i] <= 1'b0;
            end
        end else if (en) begin
            r_cv[0] <= s_valid;
            for (int i = 1; i <= CORDIC_STAGES; i++) begin
                r_cv[i] <= r_cv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cf[0] <= s_geo.flag;
            for (int i = 1; i <= CORDIC_STAGES; i++) begin
                r_cf[i] <= r_cf[i-1];
            end
        end
    end

    // Round half up to the output format, then saturate.
    function automatic logic signed [ikn_pkg::ANG_W-1:0] angle_out(
        input logic signed [ikn_pkg::ZW:0] a
    );
        logic signed [AW-1:0] t;
        t = $signed({a[ikn_pkg::ZW], a}) + HALF;
        t = t >>> SH;
        if (t > ANG_HI) begin
            t = ANG_HI;
        end else if (t < ANG_LO) begin
            t = ANG_LO;
        end
        angle_out = t[ikn_pkg::ANG_W-1:0];
    endfunction

    logic signed [ikn_pkg::ZW:0] n_th1, n_th2;

    always_comb begin
        n_th1 = $signed({z_xy[ikn_pkg::ZW-1], z_xy}) - $signed({z_k[ikn_pkg::ZW-1], z_k});
        n_th2 = $signed({z_el[ikn_pkg::ZW-1], z_el});
    end

    logic                              r_tv, r_tf;
    logic signed [ikn_pkg::ANG_W-1:0]  r_tsh, r_tel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else if (en) begin
            r_tv <= r_cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tsh <= angle_out(n_th1);
            r_tel <= angle_out(n_th2);
            r_tf  <= r_cf[CORDIC_STAGES];
        end
    end

    // Output register with a one-entry skid behind it.
    logic signed [ikn_pkg::ANG_W-1:0] r_osh, r_oel, r_ssh, r_sel;
    logic                             r_of, r_sf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_tv;
            end
        end else if (r_tv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_ready) begin
            if (r_sv) begin
                r_osh <= r_ssh;
                r_oel <= r_sel;
                r_of  <= r_sf;
            end else begin
                r_osh <= r_tsh;
                r_oel <= r_tel;
                r_of  <= r_tf;
            end
        end else if (en) begin
            r_ssh <= r_tsh;
            r_sel <= r_tel;
            r_sf  <= r_tf;
        end
    end

    assign o_valid          = r_ov;
    assign o_shoulder_angle = r_osh;
    assign o_elbow_angle    = r_oel;
    assign o_out_of_reach   = r_of;

    // The skid register only ever holds a result behind a waiting one.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid register full while output register empty");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |=> !r_sv)
        else $error("skid register filled while output register was empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !i_ready))
        else $error("skid register filled without a stalled result");

endmodule
